FILE: hw/rtl/swrt_pkg.sv
// Package for the send window and RTT tracker.
// Holds the sizes, register indexes, reset values and the
// controller-to-datapath command and status types.
package swrt_pkg;

  // Window store geometry (depth is a power of two)
  localparam int WINDOW_DEPTH = 64;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

  // Field widths fixed by the interface
  localparam int SEQ_W     = 31;
  localparam int TIME_W    = 32;
  localparam int LIMIT_W   = 7;
  localparam int DUP_W     = 4;
  localparam int COUNT_W   = 7;
  localparam int ENTRY_W   = SEQ_W + TIME_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RTT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_THRESHOLD = 2'd2;

  // Reset values of the configuration registers
  localparam logic [LIMIT_W-1:0] WINDOW_LIMIT_RST  = 7'd64;
  localparam logic [TIME_W-1:0]  INITIAL_RTT_RST   = 32'd50000;
  localparam logic [DUP_W-1:0]   DUP_THRESHOLD_RST = 4'd3;
  localparam logic [DUP_W-1:0]   DUP_MAX           = 4'd15;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // capture an item and run the duplicate ack logic
    logic send;       // append a segment if the window has room
    logic eval;       // examine the entry read from the window store
    logic srtt;       // smoothed RTT step
    logic dev;        // absolute deviation step
    logic var_upd;    // deviation average step
    logic rto;        // timeout step
    logic fin;        // close the ack pass
    logic load_out;   // load the result register
  } swrt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_is_ack;  // op field of the item on the input channel
    logic more;       // entries left to examine in the ack pass
    logic update;     // examined entry is released and its sample is in range
  } swrt_status_t;

endpackage

FILE: hw/rtl/swrt_in_if.sv
// Input channel of the send window and RTT tracker.
// Valid/ready handshake with the item fields; depends on swrt_pkg.
interface swrt_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [swrt_pkg::SEQ_W-1:0]  seq_num;
  logic [swrt_pkg::SEQ_W-1:0]  ack_num;
  logic [swrt_pkg::TIME_W-1:0] now_us;

  modport source (output valid, op, seq_num, ack_num, now_us, input ready);
  modport sink   (input valid, op, seq_num, ack_num, now_us, output ready);
endinterface

FILE: hw/rtl/swrt_out_if.sv
// Result channel of the send window and RTT tracker.
// Valid/ready handshake with the result fields; depends on swrt_pkg.
interface swrt_out_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic [swrt_pkg::COUNT_W-1:0] removed_count;
  logic [swrt_pkg::COUNT_W-1:0] window_count;
  logic [swrt_pkg::TIME_W-1:0]  timeout_us;
  logic                         fast_retransmit;
  logic [swrt_pkg::SEQ_W-1:0]   oldest_seq;

  modport source (output valid, accepted, removed_count, window_count, timeout_us,
                  fast_retransmit, oldest_seq, input ready);
  modport sink   (input valid, accepted, removed_count, window_count, timeout_us,
                  fast_retransmit, oldest_seq, output ready);
endinterface

FILE: hw/rtl/swrt_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module swrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/swrt_ctrl.sv
// Controller state machine of the send window and RTT tracker.
// Drives the datapath through swrt_cmd_t and owns the channel handshakes.
module swrt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  swrt_pkg::swrt_status_t status,
  output swrt_pkg::swrt_cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SEND = 10'b0000000010,
    S_RD   = 10'b0000000100,
    S_EVAL = 10'b0000001000,
    S_SRTT = 10'b0000010000,
    S_DEV  = 10'b0000100000,
    S_VARU = 10'b0001000000,
    S_RTO  = 10'b0010000000,
    S_FIN  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state, commands and result handshake
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = status.in_is_ack ? S_RD : S_SEND;
        end
      end
      S_SEND: begin
        cmd.send  = 1'b1;
        state_nxt = S_DONE;
      end
      // The read address is the pass counter; data arrives in S_EVAL
      S_RD: begin
        state_nxt = status.more ? S_EVAL : S_FIN;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = status.update ? S_SRTT : S_RD;
      end
      S_SRTT: begin
        cmd.srtt  = 1'b1;
        state_nxt = S_DEV;
      end
      S_DEV: begin
        cmd.dev   = 1'b1;
        state_nxt = S_VARU;
      end
      S_VARU: begin
        cmd.var_upd = 1'b1;
        state_nxt   = S_RTO;
      end
      S_RTO: begin
        cmd.rto   = 1'b1;
        state_nxt = S_RD;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/swrt_dp.sv
// Datapath of the send window and RTT tracker: window store, RTT estimator,
// duplicate ack counter, configuration registers and result register.
// Depends on swrt_pkg and swrt_ram.
module swrt_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration
  input  logic                               cfg_we,
  input  logic [swrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swrt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // Input item fields
  input  logic                               in_op,
  input  logic [swrt_pkg::SEQ_W-1:0]         in_seq_num,
  input  logic [swrt_pkg::SEQ_W-1:0]         in_ack_num,
  input  logic [swrt_pkg::TIME_W-1:0]        in_now_us,
  // Result fields
  output logic                               out_accepted,
  output logic [swrt_pkg::COUNT_W-1:0]       out_removed_count,
  output logic [swrt_pkg::COUNT_W-1:0]       out_window_count,
  output logic [swrt_pkg::TIME_W-1:0]        out_timeout_us,
  output logic                               out_fast_retransmit,
  output logic [swrt_pkg::SEQ_W-1:0]         out_oldest_seq,
  // Controller link
  input  swrt_pkg::swrt_cmd_t                cmd,
  output swrt_pkg::swrt_status_t             status
);

  // Configuration registers
  logic [swrt_pkg::LIMIT_W-1:0] window_limit_r;
  logic [swrt_pkg::DUP_W-1:0]   dup_thr_r;

  // Captured item
  logic [swrt_pkg::SEQ_W-1:0]  seq_in_r;
  logic [swrt_pkg::SEQ_W-1:0]  ack_r;
  logic [swrt_pkg::TIME_W-1:0] now_r;

  // Window and ack pass state
  logic [swrt_pkg::CNT_W-1:0]  occ_r;
  logic [swrt_pkg::CNT_W-1:0]  k_r;
  logic [swrt_pkg::CNT_W-1:0]  w_r;
  logic [swrt_pkg::SEQ_W-1:0]  oldest_r;
  logic [swrt_pkg::COUNT_W-1:0] removed_r;
  logic                        accepted_r;

  // Estimator state
  logic [swrt_pkg::TIME_W-1:0] srtt_r;
  logic [swrt_pkg::TIME_W-1:0] var_r;
  logic [swrt_pkg::TIME_W-1:0] rto_r;
  logic [swrt_pkg::TIME_W-1:0] sample_r;
  logic [swrt_pkg::TIME_W-1:0] dev_r;

  // Duplicate ack state
  logic [swrt_pkg::SEQ_W-1:0]  last_ack_r;
  logic                        ack_seen_r;
  logic [swrt_pkg::DUP_W-1:0]  dup_r;
  logic                        fast_r;

  // Result register
  logic                         res_accepted_r;
  logic [swrt_pkg::COUNT_W-1:0] res_removed_r;
  logic [swrt_pkg::COUNT_W-1:0] res_window_r;
  logic [swrt_pkg::TIME_W-1:0]  res_timeout_r;
  logic                         res_fast_r;
  logic [swrt_pkg::SEQ_W-1:0]   res_oldest_r;

  // Window store access
  logic                          ram_we;
  logic [swrt_pkg::PTR_W-1:0]    ram_waddr;
  logic [swrt_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [swrt_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [swrt_pkg::SEQ_W-1:0]    rd_seq;
  logic [swrt_pkg::TIME_W-1:0]   rd_stamp;

  // Combinational helpers
  logic                          room;
  logic                          hit;
  logic [swrt_pkg::TIME_W-1:0]   sample;
  logic                          in_range;
  logic                          is_dup;
  logic [swrt_pkg::DUP_W-1:0]    dup_inc;
  logic [swrt_pkg::TIME_W+2:0]   srtt_sum;
  logic [swrt_pkg::TIME_W+1:0]   var_sum;
  logic [swrt_pkg::TIME_W+2:0]   rto_sum;

  assign rd_seq   = ram_rdata[swrt_pkg::ENTRY_W-1:swrt_pkg::TIME_W];
  assign rd_stamp = ram_rdata[swrt_pkg::TIME_W-1:0];

  // Window store: survivors of an ack are packed toward slot zero in order
  swrt_ram #(
    .WIDTH (swrt_pkg::ENTRY_W),
    .DEPTH (swrt_pkg::WINDOW_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (k_r[swrt_pkg::PTR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Room in the window under the effective limit
  assign room = ((swrt_pkg::LIMIT_W + swrt_pkg::CNT_W)'(occ_r) <
                 (swrt_pkg::LIMIT_W + swrt_pkg::CNT_W)'(window_limit_r)) &&
                (occ_r < swrt_pkg::CNT_W'(swrt_pkg::WINDOW_DEPTH));

  // Examination of the entry read back from the store
  assign hit      = (rd_seq <= ack_r);
  assign sample   = now_r - rd_stamp;
  assign in_range = ({1'b0, sample} <= {rto_r, 1'b0});

  // Store write select: append on a send, pack a survivor on an ack pass
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w_r[swrt_pkg::PTR_W-1:0];
    ram_wdata = ram_rdata;
    if (cmd.send) begin
      ram_we    = room;
      ram_waddr = occ_r[swrt_pkg::PTR_W-1:0];
      ram_wdata = {seq_in_r, now_r};
    end else if (cmd.eval) begin
      ram_we = !hit;
    end
  end

  // Duplicate ack detection on the incoming item
  assign is_dup  = ack_seen_r && (in_ack_num == last_ack_r);
  assign dup_inc = (dup_r == swrt_pkg::DUP_MAX) ? dup_r : dup_r + 1'b1;

  // Estimator arithmetic, one step per command
  assign srtt_sum = {srtt_r, 3'b000} - {3'b000, srtt_r} + {3'b000, sample_r};
  assign var_sum  = {2'b00, var_r} + {1'b0, var_r, 1'b0} + {2'b00, dev_r};
  assign rto_sum  = {3'b000, srtt_r} + {1'b0, var_r, 2'b00};

  assign status.in_is_ack = in_op;
  assign status.more      = (k_r < occ_r);
  assign status.update    = hit && in_range;

  // Configuration, window and estimator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_limit_r <= swrt_pkg::WINDOW_LIMIT_RST;
      dup_thr_r      <= swrt_pkg::DUP_THRESHOLD_RST;
      srtt_r         <= swrt_pkg::INITIAL_RTT_RST;
      rto_r          <= swrt_pkg::INITIAL_RTT_RST;
      var_r          <= '0;
      occ_r          <= '0;
      k_r            <= '0;
      w_r            <= '0;
      ack_seen_r     <= 1'b0;
      dup_r          <= '0;
      fast_r         <= 1'b0;
      accepted_r     <= 1'b0;
      removed_r      <= '0;
    end else begin
      // The user must write registers only while the block is idle; the block itself does not enforce it
      if (cfg_we) begin
        unique case (cfg_index)
          swrt_pkg::CFG_WINDOW_LIMIT: begin
            window_limit_r <= cfg_wdata[swrt_pkg::LIMIT_W-1:0];
          end
          swrt_pkg::CFG_INITIAL_RTT: begin
            srtt_r <= cfg_wdata[swrt_pkg::TIME_W-1:0];
            rto_r  <= cfg_wdata[swrt_pkg::TIME_W-1:0];
            var_r  <= '0;
          end
          swrt_pkg::CFG_DUP_THRESHOLD: begin
            dup_thr_r <= cfg_wdata[swrt_pkg::DUP_W-1:0];
          end
          default: begin
          end
        endcase
      end

      // New item: clear the pass and handle duplicate acks
      if (cmd.accept) begin
        k_r        <= '0;
        w_r        <= '0;
        accepted_r <= 1'b0;
        removed_r  <= '0;
        fast_r     <= 1'b0;
        if (in_op) begin
          ack_seen_r <= 1'b1;
          if (is_dup) begin
            dup_r  <= dup_inc;
            fast_r <= (dup_inc == dup_thr_r);
          end else begin
            dup_r <= '0;
          end
        end
      end

      // Send: append at the tail
      if (cmd.send && room) begin
        occ_r      <= occ_r + 1'b1;
        accepted_r <= 1'b1;
      end

      // Ack pass: count survivors and advance
      if (cmd.eval) begin
        k_r <= k_r + 1'b1;
        if (!hit) begin
          w_r <= w_r + 1'b1;
        end
      end

      // Jacobson update, one step per cycle
      if (cmd.srtt) begin
        srtt_r <= srtt_sum[swrt_pkg::TIME_W+2:3];
      end
      if (cmd.var_upd) begin
        var_r <= var_sum[swrt_pkg::TIME_W+1:2];
      end
      if (cmd.rto) begin
        rto_r <= (rto_sum[swrt_pkg::TIME_W+2:swrt_pkg::TIME_W] != 3'b000) ?
                 '1 : rto_sum[swrt_pkg::TIME_W-1:0];
      end

      // End of the ack pass: survivors form the new window
      if (cmd.fin) begin
        occ_r     <= w_r;
        removed_r <= swrt_pkg::COUNT_W'(occ_r - w_r);
      end
    end
  end

  // Payload registers without reset
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      seq_in_r <= in_seq_num;
      ack_r    <= in_ack_num;
      now_r    <= in_now_us;
      if (in_op) begin
        last_ack_r <= in_ack_num;
      end
    end
    if (cmd.send && room && (occ_r == '0)) begin
      oldest_r <= seq_in_r;
    end
    if (cmd.eval) begin
      sample_r <= sample;
      if (!hit && (w_r == '0)) begin
        oldest_r <= rd_seq;
      end
    end
    if (cmd.dev) begin
      dev_r <= (sample_r >= srtt_r) ? sample_r - srtt_r : srtt_r - sample_r;
    end
    if (cmd.load_out) begin
      res_accepted_r <= accepted_r;
      res_removed_r  <= removed_r;
      res_window_r   <= swrt_pkg::COUNT_W'(occ_r);
      res_timeout_r  <= rto_r;
      res_fast_r     <= fast_r;
      res_oldest_r   <= (occ_r != '0) ? oldest_r : '0;
    end
  end

  assign out_accepted        = res_accepted_r;
  assign out_removed_count   = res_removed_r;
  assign out_window_count    = res_window_r;
  assign out_timeout_us      = res_timeout_r;
  assign out_fast_retransmit = res_fast_r;
  assign out_oldest_seq      = res_oldest_r;

endmodule

FILE: hw/rtl/send_window_rtt_tracker_core.sv
// Send window and RTT tracker, top level. One item is in work at a time.
// A send passes through S_SEND to S_DONE; an ack reads and examines each of the N segments
// in the window, and each of the U released segments whose sample is in range takes
// the four-step estimator update (S_SRTT, S_DEV, S_VARU, S_RTO) before the pass closes.
// An item holds the block until its result is loaded, which also waits for the sink.
// Synchronous active-low reset restores the register defaults and empties the window.
module send_window_rtt_tracker_core (
  input  logic                            clk,
  input  logic                            rst_n,
  swrt_in_if.sink                         in_if,
  swrt_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [swrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swrt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  swrt_pkg::swrt_cmd_t    cmd;
  swrt_pkg::swrt_status_t status;

  // Sequencer
  swrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Window store and estimator
  swrt_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_op               (in_if.op),
    .in_seq_num          (in_if.seq_num),
    .in_ack_num          (in_if.ack_num),
    .in_now_us           (in_if.now_us),
    .out_accepted        (out_if.accepted),
    .out_removed_count   (out_if.removed_count),
    .out_window_count    (out_if.window_count),
    .out_timeout_us      (out_if.timeout_us),
    .out_fast_retransmit (out_if.fast_retransmit),
    .out_oldest_seq      (out_if.oldest_seq),
    .cmd                 (cmd),
    .status              (status)
  );

  // Only one item is in work: the input closes after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input accepted while an item is in work");

  // Loading the result register always presents a result
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_if.valid)
    else $error("result loaded but not presented");

  // A result never reports a send acceptance and released segments together
  a_send_ack_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> !(out_if.accepted && (out_if.removed_count != '0)))
    else $error("send and ack fields both set");

  // The window never holds more than the store depth
  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.window_count <= swrt_pkg::COUNT_W'(swrt_pkg::WINDOW_DEPTH)))
    else $error("window count beyond store depth");

endmodule

FILE: tb/sv/send_window_rtt_tracker_core_test.sv
// Self-checking testbench for send_window_rtt_tracker_core: a built-in window and
// RTT estimator predicts each result, and directed then random items are checked.
// Depends on swrt_pkg, swrt_in_if, swrt_out_if and the core itself.
module send_window_rtt_tracker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import swrt_pkg::*;

  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned TAIL_CYCLES = 400;
  localparam int unsigned IDLE_PCT    = 23;
  localparam logic        OP_SEND     = 1'b0;
  localparam logic        OP_ACK      = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] stamp;
  } segment_t;

  typedef struct packed {
    logic               accepted;
    logic [COUNT_W-1:0] removed;
    logic [COUNT_W-1:0] window;
    logic [TIME_W-1:0]  timeout;
    logic               fast;
    logic [SEQ_W-1:0]   oldest;
  } window_report_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  swrt_in_if  in_ch ();
  swrt_out_if out_ch ();

  send_window_rtt_tracker_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Mirror of the block state: the outstanding window in age order and the estimator.
  segment_t         outstanding[$];
  logic [LIMIT_W-1:0] win_limit;
  logic [DUP_W-1:0]   dup_trigger;
  logic [DUP_W-1:0]   dup_run;
  logic [TIME_W-1:0]  est_srtt;
  logic [TIME_W-1:0]  est_rttvar;
  logic [TIME_W-1:0]  est_rto;
  logic [31:0]        seen_ack;

  // Reports predicted for accepted items, oldest first.
  window_report_t report_fifo[$];

  // Stimulus state.
  bit                stall_free;
  int unsigned       fill_goal;
  int unsigned       dup_left;
  logic [SEQ_W-1:0]  next_seq;
  logic [TIME_W-1:0] clock_us;

  int unsigned    mismatch_count;
  int unsigned    cycle_count;
  window_report_t want;
  window_report_t got;

  // One Jacobson estimator step for a released segment.
  function automatic void rtt_fold(logic [TIME_W-1:0] stamp, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] sample;
    logic [TIME_W-1:0] dev;
    logic [63:0]       wide;
    sample = now - stamp;
    if ({32'd0, sample} > ({32'd0, est_rto} << 1)) return;
    wide     = (64'd7 * {32'd0, est_srtt} + {32'd0, sample}) >> 3;
    est_srtt = wide[31:0];
    dev      = (sample >= est_srtt) ? sample - est_srtt : est_srtt - sample;
    wide       = (64'd3 * {32'd0, est_rttvar} + {32'd0, dev}) >> 2;
    est_rttvar = wide[31:0];
    wide    = {32'd0, est_srtt} + ({32'd0, est_rttvar} << 2);
    est_rto = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

  // Applies one item to the mirrored state and returns the report it causes.
  function automatic window_report_t window_step(logic op, logic [SEQ_W-1:0] seq,
                                                 logic [SEQ_W-1:0] ack,
                                                 logic [TIME_W-1:0] now);
    window_report_t r;
    segment_t       kept[$];
    int unsigned    lim;
    r   = '0;
    lim = (win_limit < WINDOW_DEPTH) ? win_limit : WINDOW_DEPTH;
    if (op == OP_SEND) begin
      if (outstanding.size() < lim) begin
        outstanding.push_back(segment_t'{seq, now});
        r.accepted = 1'b1;
      end
    end else begin
      if ({1'b0, ack} == seen_ack) begin
        if (dup_run != DUP_MAX) dup_run++;
        if (dup_run == dup_trigger) r.fast = 1'b1;
      end else begin
        dup_run = '0;
      end
      seen_ack = {1'b0, ack};
      // Release every segment at or below the ack, oldest first; survivors keep order.
      foreach (outstanding[k]) begin
        if (outstanding[k].seq <= ack) begin
          rtt_fold(outstanding[k].stamp, now);
          r.removed++;
        end else begin
          kept.push_back(outstanding[k]);
        end
      end
      outstanding = kept;
    end
    r.window  = COUNT_W'(outstanding.size());
    r.timeout = est_rto;
    r.oldest  = (outstanding.size() != 0) ? outstanding[0].seq : '0;
    return r;
  endfunction

  // Offers one item, waits for it to be taken and records its predicted report.
  task automatic push_item(logic op, logic [SEQ_W-1:0] seq, logic [SEQ_W-1:0] ack,
                           logic [TIME_W-1:0] now);
    if (!stall_free) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.seq_num <= seq;
    in_ch.ack_num <= ack;
    in_ch.now_us  <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    report_fifo.push_back(window_step(op, seq, ack, now));
  endtask

  // Stops offering items and waits until every predicted report has been seen.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (report_fifo.size() != 0) @(posedge clk);
  endtask

  // Writes all three registers back to back once the block is idle.
  task automatic set_registers(logic [LIMIT_W-1:0] limit, logic [TIME_W-1:0] rtt,
                               logic [DUP_W-1:0] thr);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW_LIMIT;
    cfg_wdata <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_index <= CFG_INITIAL_RTT;
    cfg_wdata <= rtt;
    @(posedge clk);
    cfg_index <= CFG_DUP_THRESHOLD;
    cfg_wdata <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_we      <= 1'b0;
    win_limit   = limit;
    est_srtt    = rtt;
    est_rto     = rtt;
    est_rttvar  = '0;
    dup_trigger = thr;
  endtask

  // Field extremes, wrapped time stamps, out-of-range samples, unordered
  // sequence numbers and the duplicate ack count passing the threshold.
  task automatic test_basics();
    push_item(OP_ACK,  31'd0,            31'd0,  32'd0);
    push_item(OP_SEND, 31'h7FFF_FFFF,    31'd0,  32'hFFFF_FFF0);
    push_item(OP_SEND, 31'd0,            31'd0,  32'hFFFF_FFFF);
    push_item(OP_SEND, 31'd100,          31'd0,  32'd0);
    push_item(OP_ACK,  31'h7FFF_FFFF,    31'd99, 32'd16);
    repeat (4) push_item(OP_ACK, 31'd0, 31'd99, 32'd20);
    push_item(OP_ACK,  31'd0, 31'h7FFF_FFFF, 32'd200_000);
  endtask

  // Full window, a zero limit, and a limit lowered beneath the occupancy.
  task automatic test_window_limits();
    set_registers(7'd1, INITIAL_RTT_RST, DUP_THRESHOLD_RST);
    push_item(OP_SEND, 31'd500, 31'd0,   32'd1000);
    push_item(OP_SEND, 31'd501, 31'd0,   32'd1100);
    push_item(OP_ACK,  31'd0,   31'd500, 32'd1500);
    set_registers(7'd0, INITIAL_RTT_RST, DUP_THRESHOLD_RST);
    push_item(OP_SEND, 31'd502, 31'd0,   32'd1600);
    set_registers(7'd64, INITIAL_RTT_RST, DUP_THRESHOLD_RST);
    for (int i = 0; i < 4; i++) push_item(OP_SEND, 31'(600 + i), 31'd0, 32'(2000 + 10 * i));
    set_registers(7'd2, INITIAL_RTT_RST, DUP_THRESHOLD_RST);
    push_item(OP_SEND, 31'd604, 31'd0,   32'd2100);
    push_item(OP_ACK,  31'd0,   31'd601, 32'd2200);
    push_item(OP_ACK,  31'd0,   31'd603, 32'd2300);
  endtask

  // A zero starting timeout, a maximal one that saturates, and thresholds 0 and 1.
  task automatic test_rtt_extremes();
    set_registers(7'd64, 32'd0, 4'd0);
    push_item(OP_SEND, 31'd10, 31'd0,  32'd1000);
    push_item(OP_ACK,  31'd0,  31'd10, 32'd1000);
    push_item(OP_SEND, 31'd11, 31'd0,  32'd5);
    push_item(OP_ACK,  31'd0,  31'd11, 32'd6);
    push_item(OP_ACK,  31'd0,  31'd11, 32'd7);
    set_registers(7'd64, 32'hFFFF_FFFF, 4'd1);
    push_item(OP_SEND, 31'd1, 31'd0, 32'd0);
    push_item(OP_ACK,  31'd0, 31'd1, 32'hFFFF_FFFF);
    push_item(OP_SEND, 31'd2, 31'd0, 32'd0);
    push_item(OP_ACK,  31'd0, 31'd2, 32'd0);
    push_item(OP_ACK,  31'd0, 31'd2, 32'd0);
  endtask

  // Mostly in-order traffic with random timing, bursts of duplicate acks and some noise.
  task automatic random_item();
    logic              op;
    logic [SEQ_W-1:0]  seq_f;
    logic [SEQ_W-1:0]  ack_f;
    logic [TIME_W-1:0] now_f;
    int unsigned       roll;
    int unsigned       pos;
    roll  = $urandom_range(99);
    seq_f = SEQ_W'($urandom);
    ack_f = SEQ_W'($urandom);
    now_f = clock_us;
    op    = OP_ACK;
    if ($urandom_range(29) == 0) fill_goal = $urandom_range(0, 70);
    if (dup_left != 0) begin
      dup_left--;
      ack_f = seen_ack[SEQ_W-1:0];
    end else if (roll < 8) begin
      op    = 1'($urandom_range(1));
      now_f = $urandom;
    end else if (roll < 11) begin
      dup_left = $urandom_range(1, 18);
      ack_f    = seen_ack[SEQ_W-1:0];
    end else if (roll < 70 && outstanding.size() < fill_goal) begin
      op       = OP_SEND;
      seq_f    = next_seq;
      next_seq = next_seq + SEQ_W'($urandom_range(1, 1460));
    end else if (outstanding.size() != 0) begin
      pos   = $urandom_range(outstanding.size() - 1);
      ack_f = outstanding[pos].seq;
      // Now and then an ack below the head that releases nothing.
      if ($urandom_range(7) == 0) ack_f = outstanding[0].seq - 31'd1;
    end
    clock_us = clock_us + TIME_W'($urandom_range(0, 4000));
    if ($urandom_range(39) == 0) clock_us = clock_us + TIME_W'($urandom_range(0, 500_000));
    push_item(op, seq_f, ack_f, now_f);
  endtask

  task automatic test_random_traffic(logic [LIMIT_W-1:0] limit, logic [TIME_W-1:0] rtt,
                                     logic [DUP_W-1:0] thr, int unsigned count, bit calm);
    set_registers(limit, rtt, thr);
    stall_free = calm;
    fill_goal  = $urandom_range(1, 70);
    dup_left   = 0;
    next_seq   = SEQ_W'($urandom_range(0, 32'h7FF0_0000));
    clock_us   = $urandom;
    repeat (count) random_item();
    wait_idle();
    stall_free = 1'b0;
  endtask

  // Result side: random back-pressure, and each report checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.accepted, out_ch.removed_count, out_ch.window_count,
              out_ch.timeout_us, out_ch.fast_retransmit, out_ch.oldest_seq};
      if (report_fifo.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result at cycle %0d", cycle_count);
      end else begin
        want = report_fifo.pop_front();
        if (got.accepted !== want.accepted || got.removed !== want.removed ||
            got.window !== want.window || got.timeout !== want.timeout ||
            got.fast !== want.fast || got.oldest !== want.oldest) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch at cycle %0d", cycle_count);
            $display("  want acc=%0d rem=%0d win=%0d rto=%0d fast=%0d oldest=%0h",
                     want.accepted, want.removed, want.window, want.timeout,
                     want.fast, want.oldest);
            $display("  got  acc=%0d rem=%0d win=%0d rto=%0d fast=%0d oldest=%0h",
                     got.accepted, got.removed, got.window, got.timeout,
                     got.fast, got.oldest);
          end
        end
      end
    end
    out_ch.ready <= stall_free || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.op      <= OP_SEND;
    in_ch.seq_num <= '0;
    in_ch.ack_num <= '0;
    in_ch.now_us  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_WINDOW_LIMIT;
    cfg_wdata     <= '0;
    mismatch_count = 0;
    stall_free     = 1'b0;
    dup_left       = 0;
    // State after reset.
    win_limit   = WINDOW_LIMIT_RST;
    dup_trigger = DUP_THRESHOLD_RST;
    dup_run     = '0;
    est_srtt    = INITIAL_RTT_RST;
    est_rttvar  = '0;
    est_rto     = INITIAL_RTT_RST;
    seen_ack    = 32'hFFFF_FFFF;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basics();
    test_window_limits();
    test_rtt_extremes();
    test_random_traffic(7'd64,  32'd50_000,     4'd3,  350, 1'b0);
    test_random_traffic(7'd8,   32'd1000,       4'd1,  300, 1'b1);
    test_random_traffic(7'd127, 32'd20_000,     4'd15, 350, 1'b0);
    test_random_traffic(7'd3,   32'hFFFF_FFFF,  4'd2,  250, 1'b0);
    test_random_traffic(7'd100, 32'd30_000,     4'd0,  300, 1'b0);
    test_random_traffic(7'd1,   32'd5000,       4'd4,  150, 1'b0);
    test_random_traffic(7'd64,  32'd0,          4'd7,  150, 1'b0);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && report_fifo.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: send_window_rtt_tracker_core.f
hw/rtl/swrt_pkg.sv
hw/rtl/swrt_in_if.sv
hw/rtl/swrt_out_if.sv
hw/rtl/swrt_ram.sv
hw/rtl/swrt_ctrl.sv
hw/rtl/swrt_dp.sv
hw/rtl/send_window_rtt_tracker_core.sv
tb/sv/send_window_rtt_tracker_core_test.sv
